>>> hw/rtl/sct_pkg.sv
`timescale 1ns / 1ps

package sct_pkg;

  // Field widths of the request and result ports.
  localparam int unsigned KEY_W  = 27;
  localparam int unsigned PACK_W = 2 * KEY_W;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned HDL_W  = 10;

  // Default number of table entries.
  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // Latch a new request and open the search window.
    logic rd_mid;      // Read the entry at the middle of the window.
    logic cmp;         // Compare the read entry and narrow the window.
    logic flag_full;   // Record that an insert was refused.
    logic shift_init;  // Point the move index at the top of the table.
    logic rd_prev;     // Read the entry just below the move index.
    logic wr_prev;     // Write that entry one slot up and step down.
    logic wr_new;      // Write the new entry at the insertion point.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_done;  // Match found or window empty.
    logic need_insert;  // Miss on a request that asks for an insert.
    logic full;         // No free slot left.
    logic shift_done;   // Move index has reached the insertion point.
  } status_t;

endpackage

>>> hw/rtl/sct_datapath.sv
`timescale 1ns / 1ps

module sct_datapath #(
  parameter int unsigned TABLE_DEPTH = sct_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sct_pkg::cmd_t              cmd_i,
  output sct_pkg::status_t           status_o,
  input  logic                       func_i,
  input  logic signed [sct_pkg::KEY_W-1:0] key_x_i,
  input  logic signed [sct_pkg::KEY_W-1:0] key_y_i,
  output logic                       found_o,
  output logic                       inserted_o,
  output logic                       full_error_o,
  output logic [sct_pkg::POS_W-1:0]  position_o,
  output logic [sct_pkg::HDL_W-1:0]  node_handle_o
);

  import sct_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENT_W = PACK_W + IDX_W;

  // Each entry holds the packed key above its handle.
  logic [ENT_W-1:0] mem_q [TABLE_DEPTH];
  logic [ENT_W-1:0] rdata_q;

  logic [PACK_W-1:0] key_q;
  logic              func_q;
  logic [CNT_W-1:0]  lo_q, hi_q, cnt_q, idx_q;
  logic              found_q, inserted_q, full_q;
  logic [IDX_W-1:0]  handle_q;

  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  idx_m1;
  logic [IDX_W-1:0]  raddr;
  logic [PACK_W-1:0] ent_key;
  logic [PACK_W-1:0] in_key;

  // Keys are stored as offset binary so that an unsigned compare orders them.
  assign in_key = {~key_x_i[KEY_W-1], key_x_i[KEY_W-2:0],
                   ~key_y_i[KEY_W-1], key_y_i[KEY_W-2:0]};

  // Middle of the search window and the address of the entry below the move index.
  assign sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = sum[CNT_W:1];
  assign idx_m1  = idx_q - 1'b1;
  assign raddr   = cmd_i.rd_mid ? mid[IDX_W-1:0] : idx_m1[IDX_W-1:0];
  assign ent_key = rdata_q[ENT_W-1:IDX_W];

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_prev) begin
      mem_q[idx_q[IDX_W-1:0]] <= rdata_q;
    end else if (cmd_i.wr_new) begin
      mem_q[lo_q[IDX_W-1:0]] <= {key_q, cnt_q[IDX_W-1:0]};
    end
    if (cmd_i.rd_mid || cmd_i.rd_prev) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Request payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= in_key;
      func_q <= func_i;
    end
  end

  // Search window, move index, entry count and result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q       <= '0;
      hi_q       <= '0;
      cnt_q      <= '0;
      idx_q      <= '0;
      found_q    <= 1'b0;
      inserted_q <= 1'b0;
      full_q     <= 1'b0;
      handle_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        lo_q       <= '0;
        hi_q       <= cnt_q;
        found_q    <= 1'b0;
        inserted_q <= 1'b0;
        full_q     <= 1'b0;
        handle_q   <= '0;
      end
      if (cmd_i.cmp) begin
        if (ent_key > key_q) begin
          hi_q <= mid;
        end else if (ent_key < key_q) begin
          lo_q <= mid + 1'b1;
        end else begin
          found_q  <= 1'b1;
          lo_q     <= mid;
          handle_q <= rdata_q[IDX_W-1:0];
        end
      end
      if (cmd_i.flag_full) begin
        full_q <= 1'b1;
      end
      if (cmd_i.shift_init) begin
        idx_q <= cnt_q;
      end
      if (cmd_i.wr_prev) begin
        idx_q <= idx_m1;
      end
      if (cmd_i.wr_new) begin
        handle_q   <= cnt_q[IDX_W-1:0];
        inserted_q <= 1'b1;
        cnt_q      <= cnt_q + 1'b1;
      end
    end
  end

  // Status toward the controller.
  assign status_o.search_done = found_q || (lo_q >= hi_q);
  assign status_o.need_insert = !found_q && func_q;
  assign status_o.full        = (cnt_q == CNT_W'(TABLE_DEPTH));
  assign status_o.shift_done  = (idx_q <= lo_q);

  // Result fields, widened or cut to the port widths.
  logic [CNT_W+POS_W-1:0] pos_ext;
  logic [IDX_W+HDL_W-1:0] hdl_ext;

  assign pos_ext       = {{POS_W{1'b0}}, lo_q};
  assign hdl_ext       = {{HDL_W{1'b0}}, handle_q};
  assign position_o    = pos_ext[POS_W-1:0];
  assign node_handle_o = hdl_ext[HDL_W-1:0];
  assign found_o       = found_q;
  assign inserted_o    = inserted_q;
  assign full_error_o  = full_q;

  // The entry count never passes the table depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // An insert grows the table by exactly one entry.
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_new |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("entry count did not step on insert");

  // A result never reports both an insert and a match or a refusal.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inserted_q |-> (!found_q && !full_q))
    else $error("conflicting result flags");

  // The window stays ordered while the search runs.
  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmp |=> lo_q <= hi_q || found_q)
    else $error("search window inverted");

endmodule

>>> hw/rtl/sct_ctrl.sv
`timescale 1ns / 1ps

module sct_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             done_o,
  input  sct_pkg::status_t status_i,
  output sct_pkg::cmd_t    cmd_o
);

  import sct_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_SHIFT,
    ST_MOVE,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, done_q;

  // Commands and next state from the current state and datapath status.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (!status_i.search_done) begin
          cmd_o.rd_mid = 1'b1;
          state_d      = ST_CMP;
        end else if (status_i.need_insert && status_i.full) begin
          cmd_o.flag_full = 1'b1;
          state_d         = ST_DONE;
        end else if (status_i.need_insert) begin
          cmd_o.shift_init = 1'b1;
          state_d          = ST_SHIFT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_PROBE;
      end
      ST_SHIFT: begin
        if (status_i.shift_done) begin
          cmd_o.wr_new = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = ST_MOVE;
        end
      end
      ST_MOVE: begin
        cmd_o.wr_prev = 1'b1;
        state_d       = ST_SHIFT;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register with the registered busy flag and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
      done_q  <= (state_d == ST_DONE);
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

  // A result is shown for a single cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held too long");

  // An accepted request makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy_q) |=> busy_q)
    else $error("request accepted without going busy");

  // After the result the block is free for the next request.
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !busy_q)
    else $error("block still busy after result");

endmodule

>>> hw/rtl/sorted_coordinate_table.sv
`timescale 1ns / 1ps
// Sequence: an accept step, search probes of a read and a compare each (at most log2(N+1)
// probes, rounded up, for N entries), a decision step, then on an insert a read and a write
// per entry moved up one slot and a write of the new entry, then the result strobe.
// Throughput: one request at a time, set by the sequencer, which stays busy through the
// result strobe; the next request is taken the cycle after it. The receiver cannot stall.
// Reset: entry count cleared to an empty table, table contents left undefined.

module sorted_coordinate_table #(
  parameter int unsigned TABLE_DEPTH = sct_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             func_i,
  input  logic signed [sct_pkg::KEY_W-1:0] key_x_i,
  input  logic signed [sct_pkg::KEY_W-1:0] key_y_i,
  output logic                             done_o,
  output logic                             found_o,
  output logic                             inserted_o,
  output logic                             full_error_o,
  output logic [sct_pkg::POS_W-1:0]        position_o,
  output logic [sct_pkg::HDL_W-1:0]        node_handle_o
);

  import sct_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer for search, shift and insert.
  sct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Table memory, search window and result registers.
  sct_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .func_i        (func_i),
    .key_x_i       (key_x_i),
    .key_y_i       (key_y_i),
    .found_o       (found_o),
    .inserted_o    (inserted_o),
    .full_error_o  (full_error_o),
    .position_o    (position_o),
    .node_handle_o (node_handle_o)
  );

endmodule

>>> tb/sv/tb_sorted_coordinate_table.sv
`timescale 1ns / 1ps

module tb_sorted_coordinate_table;
  import sct_pkg::*;

  localparam int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int unsigned STALL_LIMIT = 25000;
  localparam int KEY_LIMIT = 36000000;

  // One request as the driver sends it.
  typedef struct {
    bit               ins;
    logic signed [KEY_W-1:0] kx;
    logic signed [KEY_W-1:0] ky;
    bit               steady;
  } point_req_t;

  // A point that has been sent with an insert, kept for revisits.
  typedef struct {
    int kx;
    int ky;
  } point_t;

  // One result as the block reports it.
  typedef struct packed {
    logic             found;
    logic             inserted;
    logic             full_err;
    logic [POS_W-1:0] pos;
    logic [HDL_W-1:0] hdl;
  } outcome_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    func_i = 1'b0;
  logic signed [KEY_W-1:0] key_x_i = '0;
  logic signed [KEY_W-1:0] key_y_i = '0;
  logic                    done_o;
  logic                    found_o;
  logic                    inserted_o;
  logic                    full_error_o;
  logic [POS_W-1:0]        position_o;
  logic [HDL_W-1:0]        node_handle_o;

  // Local copy of the sorted table.
  logic [PACK_W-1:0] row_key [TABLE_DEPTH];
  logic [HDL_W-1:0]  row_hdl [TABLE_DEPTH];
  int unsigned       row_count = 0;

  point_req_t point_q[$];
  outcome_t   awaited_q[$];
  point_t     sent_points[$];
  int         fail_count = 0;
  int         mismatch_count = 0;

  sorted_coordinate_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .key_x_i      (key_x_i),
    .key_y_i      (key_y_i),
    .done_o       (done_o),
    .found_o      (found_o),
    .inserted_o   (inserted_o),
    .full_error_o (full_error_o),
    .position_o   (position_o),
    .node_handle_o(node_handle_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Binary search of the local table, then an insert with shift when asked
  // and there is room. Keys compare as offset binary, x above y.
  function automatic outcome_t resolve_point(bit ins, logic [PACK_W-1:0] key);
    outcome_t    r;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned i;
    r = '0;
    lo = 0;
    hi = row_count;
    while (lo < hi && !r.found) begin
      mid = (lo + hi) >> 1;
      if (row_key[mid] > key) begin
        hi = mid;
      end else if (row_key[mid] < key) begin
        lo = mid + 1;
      end else begin
        r.found = 1'b1;
        lo = mid;
        r.hdl = row_hdl[mid];
      end
    end
    r.pos = lo[POS_W-1:0];
    if (!r.found && ins) begin
      if (row_count >= TABLE_DEPTH) begin
        r.full_err = 1'b1;
      end else begin
        for (i = row_count; i > lo; i--) begin
          row_key[i] = row_key[i-1];
          row_hdl[i] = row_hdl[i-1];
        end
        row_key[lo] = key;
        row_hdl[lo] = row_count[HDL_W-1:0];
        r.hdl = row_count[HDL_W-1:0];
        row_count++;
        r.inserted = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic queue_point(bit ins, int kx, int ky, bit steady);
    point_req_t p;
    point_t     s;
    p.ins = ins;
    p.kx = KEY_W'(kx);
    p.ky = KEY_W'(ky);
    p.steady = steady;
    point_q.push_back(p);
    if (ins) begin
      s.kx = kx;
      s.ky = ky;
      sent_points.push_back(s);
    end
  endtask

  // Wait until every queued request has been taken and answered.
  task automatic wait_drained();
    while (point_q.size() != 0 || start || awaited_q.size() != 0) @(negedge clk_i);
  endtask

  // Driver: present the next request, or idle now and then. An accepted
  // request is resolved against the local table right away.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    point_req_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
      func_i <= 1'b0;
      key_x_i <= '0;
      key_y_i <= '0;
    end else if (!start || !busy) begin
      if (start) begin
        awaited_q.push_back(resolve_point(func_i, {~key_x_i[KEY_W-1], key_x_i[KEY_W-2:0],
                                                   ~key_y_i[KEY_W-1], key_y_i[KEY_W-2:0]}));
      end
      if (point_q.size() != 0 && (point_q[0].steady || $urandom_range(99) >= 7)) begin
        nxt = point_q.pop_front();
        start <= 1'b1;
        func_i <= nxt.ins;
        key_x_i <= nxt.kx;
        key_y_i <= nxt.ky;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk_i) begin : watch_proc
    outcome_t got;
    outcome_t want;
    if (rst_ni && done_o) begin
      got = {found_o, inserted_o, full_error_o, position_o, node_handle_o};
      if (awaited_q.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: found=%0d ins=%0d full=%0d pos=%0d hdl=%0d",
                   got.found, got.inserted, got.full_err, got.pos, got.hdl);
        end
      end else begin
        want = awaited_q.pop_front();
        if (got !== want) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp found=%0d ins=%0d full=%0d pos=%0d hdl=%0d",
                     want.found, want.inserted, want.full_err, want.pos, want.hdl);
            $display("          got found=%0d ins=%0d full=%0d pos=%0d hdl=%0d",
                     got.found, got.inserted, got.full_err, got.pos, got.hdl);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither a request nor a result moves.
  always @(posedge clk_i) begin : stall_proc
    int unsigned quiet;
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : stim_proc
    int     n;
    int     sel;
    int     kx;
    int     ky;
    point_t s;
    int     fill_need;

    // Directed requests: empty table, duplicates, signed ordering, extremes.
    queue_point(1'b0, -KEY_LIMIT, -KEY_LIMIT, 1'b0);
    queue_point(1'b1, 0, 0, 1'b0);
    queue_point(1'b1, 0, 0, 1'b0);
    queue_point(1'b0, 0, 0, 1'b0);
    queue_point(1'b1, -KEY_LIMIT, -KEY_LIMIT, 1'b0);
    queue_point(1'b1, KEY_LIMIT, -KEY_LIMIT, 1'b0);
    queue_point(1'b0, KEY_LIMIT, KEY_LIMIT, 1'b0);
    queue_point(1'b1, 0, -1, 1'b0);
    queue_point(1'b1, 0, 1, 1'b0);
    queue_point(1'b1, -1, 0, 1'b0);
    queue_point(1'b1, 1, 0, 1'b0);
    queue_point(1'b1, -1, -1, 1'b0);
    queue_point(1'b1, -KEY_LIMIT, KEY_LIMIT, 1'b0);
    queue_point(1'b1, KEY_LIMIT - 1, KEY_LIMIT, 1'b0);
    queue_point(1'b1, 0, KEY_LIMIT, 1'b0);
    queue_point(1'b1, 0, -KEY_LIMIT, 1'b0);
    queue_point(1'b0, 0, 2, 1'b0);
    queue_point(1'b0, -1, -1, 1'b0);
    queue_point(1'b0, KEY_LIMIT, -KEY_LIMIT, 1'b0);
    queue_point(1'b1, 33554432, -33554433, 1'b0);
    queue_point(1'b1, -33554433, 33554432, 1'b0);
    queue_point(1'b0, -KEY_LIMIT, -KEY_LIMIT + 1, 1'b0);

    // Random requests: fresh inserts, revisits of known points and their
    // neighbors, and lookups of arbitrary points. Fresh inserts and lookups
    // avoid the top x value, which the fill that follows uses.
    for (n = 0; n < 290; n++) begin
      sel = $urandom_range(99);
      if (sel < 50 || sent_points.size() == 0) begin
        if (sent_points.size() != 0 && $urandom_range(3) == 0) begin
          kx = sent_points[$urandom_range(sent_points.size() - 1)].kx;
          if (kx == KEY_LIMIT) begin
            kx = KEY_LIMIT - 1;
          end
        end else begin
          kx = int'($urandom_range(2 * KEY_LIMIT - 1)) - KEY_LIMIT;
        end
        ky = int'($urandom_range(2 * KEY_LIMIT)) - KEY_LIMIT;
        queue_point(1'b1, kx, ky, n >= 120 && n < 200);
      end else if (sel < 80) begin
        s = sent_points[$urandom_range(sent_points.size() - 1)];
        if ($urandom_range(2) == 0) begin
          s.ky = (s.ky < KEY_LIMIT) ? s.ky + 1 : s.ky - 1;
        end
        queue_point(sel < 65, s.kx, s.ky, n >= 120 && n < 200);
      end else begin
        kx = int'($urandom_range(2 * KEY_LIMIT - 1)) - KEY_LIMIT;
        ky = int'($urandom_range(2 * KEY_LIMIT)) - KEY_LIMIT;
        queue_point(1'b0, kx, ky, n >= 120 && n < 200);
      end
    end
    wait_drained();

    // Fill the rest of the table with distinct points on the top x value.
    fill_need = int'(TABLE_DEPTH - row_count);
    for (n = 0; n < fill_need; n++) begin
      queue_point(1'b1, KEY_LIMIT, -KEY_LIMIT + 7 * (n + 1), 1'b0);
    end
    wait_drained();

    // Full table: refused inserts at both ends and in between, plus hits.
    queue_point(1'b1, KEY_LIMIT, KEY_LIMIT, 1'b0);
    queue_point(1'b0, KEY_LIMIT, KEY_LIMIT, 1'b0);
    queue_point(1'b0, -KEY_LIMIT, -KEY_LIMIT, 1'b0);
    queue_point(1'b1, -KEY_LIMIT, -KEY_LIMIT, 1'b0);
    queue_point(1'b1, -KEY_LIMIT, -KEY_LIMIT + 1, 1'b0);
    queue_point(1'b1, KEY_LIMIT, -KEY_LIMIT + 7 * fill_need, 1'b0);
    queue_point(1'b1, KEY_LIMIT, -KEY_LIMIT + 7 * fill_need + 1, 1'b0);
    for (n = 0; n < 8; n++) begin
      kx = int'($urandom_range(2 * KEY_LIMIT)) - KEY_LIMIT;
      ky = int'($urandom_range(2 * KEY_LIMIT)) - KEY_LIMIT;
      queue_point(1'($urandom_range(1)), kx, ky, 1'b0);
    end
    wait_drained();

    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && awaited_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
